// ===== hdl/bcg_pkg.sv =====
package bcg_pkg;

  // default counter width
  localparam int COUNT_BITS_DEF = 16;

  // register reset values
  localparam logic [15:0] WINDOW_RST    = 16'd20;
  localparam logic [15:0] LONG_TICK_RST = 16'd200;

  // register select (cfg_paddr[2])
  localparam logic REG_WINDOW    = 1'b0;
  localparam logic REG_LONG_TICK = 1'b1;

  typedef enum logic [1:0] {
    GEST_NONE   = 2'd0,
    GEST_SINGLE = 2'd1,
    GEST_DOUBLE = 2'd2,
    GEST_LONG   = 2'd3
  } gesture_t;

endpackage

// ===== hdl/bcg_engine.sv =====
module bcg_engine import bcg_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  logic        down,
  input  logic [15:0] window,
  input  logic [15:0] long_ticks,
  output gesture_t    gesture_nxt,
  output logic        flag_nxt
);

  localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic [COUNT_BITS-1:0] held_r, held_nxt;
  logic [COUNT_BITS-1:0] gap_r, gap_nxt, gap_inc;
  logic [COUNT_BITS-1:0] long_cnt_r, long_cnt_nxt;
  logic                  latched_r, latched_nxt;
  logic                  edge_r, edge_nxt;
  logic [1:0]            tally_r, tally_nxt;
  logic                  fired_r, fired_nxt;
  logic                  flag_r;
  logic                  dbl;
  logic [CMP_W-1:0]      win_x, lpt_x;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  assign win_x = CMP_W'(window);
  assign lpt_x = CMP_W'(long_ticks);

  always_comb begin
    held_nxt     = down ? sat_inc(held_r) : '0;
    latched_nxt  = latched_r | down;
    edge_nxt     = edge_r;
    tally_nxt    = tally_r;
    gap_nxt      = gap_r;
    gap_inc      = sat_inc(gap_r);
    long_cnt_nxt = long_cnt_r;
    fired_nxt    = fired_r;
    flag_nxt     = flag_r;
    gesture_nxt  = GEST_NONE;
    dbl          = 1'b0;

    // tally a new press edge; second press in the window is a double click
    if (!edge_r) begin
      if (latched_nxt) begin
        tally_nxt = (tally_r == 2'd3) ? 2'd3 : tally_r + 2'd1;
        edge_nxt  = 1'b1;
      end
      if (tally_nxt == 2'd2) begin
        tally_nxt   = 2'd0;
        gap_nxt     = '0;
        dbl         = 1'b1;
        gesture_nxt = GEST_DOUBLE;
      end
    end

    if (!dbl) begin
      if (!down) begin
        latched_nxt = 1'b0;
        edge_nxt    = 1'b0;
      end
      if (tally_nxt == 2'd1) begin
        gap_nxt = gap_inc;
        if (CMP_W'(gap_inc) > win_x && CMP_W'(held_nxt) < win_x) begin
          tally_nxt   = 2'd0;
          gap_nxt     = '0;
          gesture_nxt = GEST_SINGLE;
        end else if (CMP_W'(held_nxt) > win_x) begin
          // held too long: pending click dropped
          tally_nxt = 2'd0;
          gap_nxt   = '0;
        end
      end
    end

    // long-press stage only runs on ticks without a click
    if (gesture_nxt == GEST_NONE) begin
      long_cnt_nxt = (!fired_r && down) ? sat_inc(long_cnt_r) : '0;
      if (CMP_W'(long_cnt_nxt) > lpt_x) begin
        fired_nxt    = 1'b1;
        long_cnt_nxt = '0;
        flag_nxt     = 1'b1;
        gesture_nxt  = GEST_LONG;
      end else if (long_cnt_nxt != COUNT_BITS'(1)) begin
        fired_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r     <= '0;
      gap_r      <= '0;
      long_cnt_r <= '0;
      latched_r  <= 1'b0;
      edge_r     <= 1'b0;
      tally_r    <= 2'd0;
      fired_r    <= 1'b0;
      flag_r     <= 1'b0;
    end else if (step_en) begin
      held_r     <= held_nxt;
      gap_r      <= gap_nxt;
      long_cnt_r <= long_cnt_nxt;
      latched_r  <= latched_nxt;
      edge_r     <= edge_nxt;
      tally_r    <= tally_nxt;
      fired_r    <= fired_nxt;
      flag_r     <= flag_nxt;
    end
  end

endmodule

// ===== hdl/button_click_gesture_detector_unit.sv =====
// Button gesture detector: single click, double click, long press.
// Datapath: an accepted input goes into the input register, then through the
// classify logic into the result register.
// Throughput: one item per cycle while the result channel is not stalled;
// the gesture state updates in one pass.
// Reset (rst_n low, synchronous): all engine counters and flags zero, registers
// back to window 20 and long-press threshold 200, both channels empty.
module button_click_gesture_detector_unit import bcg_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] key_level, [7:1] zero
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [1:0] gesture, [2] long_press_flag, [7:3] zero
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [15:0] window_r;
  logic [15:0] long_ticks_r;
  logic        cfg_wr;

  logic        in_v_r;
  logic        key_r;
  logic        advance;
  logic        out_v_r;
  gesture_t    gesture_r;
  logic        flag_r;
  gesture_t    gesture_nxt;
  logic        flag_nxt;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r     <= WINDOW_RST;
      long_ticks_r <= LONG_TICK_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_WINDOW:    window_r     <= cfg_pwdata[15:0];
        REG_LONG_TICK: long_ticks_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_WINDOW:    cfg_prdata = {16'd0, window_r};
      REG_LONG_TICK: cfg_prdata = {16'd0, long_ticks_r};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  // item moves from input register to result register when the
  // result slot is free or being drained this cycle
  assign advance   = in_v_r & (~out_v_r | out_tready);
  assign in_tready = ~in_v_r | advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      key_r <= in_tdata[0];
    end
  end

  // classify logic and gesture state; key low means pressed
  bcg_engine #(
    .COUNT_BITS (COUNT_BITS)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (advance),
    .down        (~key_r),
    .window      (window_r),
    .long_ticks  (long_ticks_r),
    .gesture_nxt (gesture_nxt),
    .flag_nxt    (flag_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      gesture_r <= gesture_nxt;
      flag_r    <= flag_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, flag_r, gesture_r};

endmodule
